// ===== rtl/cir_pkg.sv =====
`default_nettype none
package cir_pkg;

  // fixed-point constants
  localparam logic [16:0] E_ONE = 17'd65536;

  // divider operand widths: dividend, divisor, quotient
  localparam int unsigned XW = 148;
  localparam int unsigned YW = 115;
  localparam int unsigned QW = 35;

  // velocity lane order
  localparam int unsigned VAX = 0;
  localparam int unsigned VAY = 1;
  localparam int unsigned VBX = 2;
  localparam int unsigned VBY = 3;

  // per-request sideband that rides along the pipeline
  typedef struct packed {
    logic [3:0][31:0] vel;
    logic [3:0]       minus;
    logic             applied;
  } side_t;

endpackage
`default_nettype wire

// ===== rtl/cir_div_pipe.sv =====
`default_nettype none
module cir_div_pipe #(
  parameter int unsigned XW = 148,
  parameter int unsigned YW = 115,
  parameter int unsigned QW = 35
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [XW-1:0] x_i,
  input  logic [YW-1:0] y_i,
  output logic          valid_o,
  output logic [QW-1:0] q_o,
  output logic          ovf_o
);

  logic [YW-1:0] rem_q [0:QW];
  logic [QW-1:0] xlo_q [0:QW];
  logic [QW-1:0] quo_q [0:QW];
  logic [YW-1:0] div_q [0:QW];
  logic          ovf_q [0:QW];
  logic [QW:0]   vld_q;
  logic [YW-1:0] rem_nx [1:QW];
  logic [QW:1]   bit_nx;

  logic [YW-1:0] rem0;
  assign rem0 = YW'(x_i[XW-1:QW]);

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[QW-1:0], valid_i};
    end
  end

  // one restoring step per stage
  for (genvar i = 1; i <= QW; i++) begin : g_step
    logic [YW:0] trial;
    logic [YW:0] diff;
    logic        ge;
    assign trial     = {rem_q[i-1], xlo_q[i-1][QW-i]};
    assign diff      = trial - {1'b0, div_q[i-1]};
    assign ge        = (trial >= {1'b0, div_q[i-1]});
    assign rem_nx[i] = ge ? diff[YW-1:0] : trial[YW-1:0];
    assign bit_nx[i] = ge;
  end

  // head stage with quotient overflow check, then the step registers
  always_ff @(posedge clk_i) begin
    rem_q[0] <= rem0;
    xlo_q[0] <= x_i[QW-1:0];
    quo_q[0] <= '0;
    div_q[0] <= y_i;
    ovf_q[0] <= (rem0 >= y_i);
    for (int i = 1; i <= QW; i++) begin
      rem_q[i] <= rem_nx[i];
      xlo_q[i] <= xlo_q[i-1];
      quo_q[i] <= {quo_q[i-1][QW-2:0], bit_nx[i]};
      div_q[i] <= div_q[i-1];
      ovf_q[i] <= ovf_q[i-1];
    end
  end

  assign valid_o = vld_q[QW];
  assign q_o     = quo_q[QW];
  assign ovf_o   = ovf_q[QW];

endmodule
`default_nettype wire

// ===== rtl/collision_impulse_response.sv =====
`default_nettype none
// 2D impulse collision response, one body pair per clock. A request is taken
// whenever start is high (busy is always low) and its result is on the
// output ports, flagged by done_o for one cycle, after passing through nine
// stages (request capture, differences, 32x32 products, dot product, partial
// products and their sums, rounding dividend and divisor), an overflow check
// stage followed by a 35-stage restoring divider (one quotient bit per stage,
// four in parallel for the four velocity components), and the saturating
// output register. Results come out in request order and cannot be held off,
// so the consumer must be able to take one result every cycle.
module collision_impulse_response (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               restitution_we_i,
  input  logic [16:0]        restitution_i,
  input  logic signed [31:0] pos_a_x_i,
  input  logic signed [31:0] pos_a_y_i,
  input  logic signed [31:0] pos_b_x_i,
  input  logic signed [31:0] pos_b_y_i,
  input  logic signed [31:0] vel_a_x_i,
  input  logic signed [31:0] vel_a_y_i,
  input  logic signed [31:0] vel_b_x_i,
  input  logic signed [31:0] vel_b_y_i,
  input  logic [31:0]        mass_a_i,
  input  logic [31:0]        mass_b_i,
  output logic               done_o,
  output logic signed [31:0] new_vel_a_x_o,
  output logic signed [31:0] new_vel_a_y_o,
  output logic signed [31:0] new_vel_b_x_o,
  output logic signed [31:0] new_vel_b_y_o,
  output logic               applied_o
);
  import cir_pkg::*;

  localparam int unsigned LAT = 9 + QW + 2;

  function automatic logic [31:0] sat32(input logic signed [37:0] v);
    logic [31:0] r;
    if (v > 38'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (v < -38'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  logic        accept;
  logic [16:0] restitution_q;
  logic [17:0] f;
  logic [9:1]  vld_q;
  side_t       sb_q [2:9];

  assign busy   = 1'b0;
  assign accept = start & ~busy;
  assign f      = 18'(restitution_q) + 18'(E_ONE);

  // restitution register, clamped to 1.0
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restitution_q <= E_ONE;
    end else if (restitution_we_i) begin
      restitution_q <= (restitution_i > E_ONE) ? E_ONE : restitution_i;
    end
  end

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[8:1], accept};
    end
  end

  // stage 1: request capture
  logic [31:0]      pax_q, pay_q, pbx_q, pby_q, ma1_q, mb1_q;
  logic [3:0][31:0] vel1_q;
  always_ff @(posedge clk_i) begin
    pax_q       <= pos_a_x_i;
    pay_q       <= pos_a_y_i;
    pbx_q       <= pos_b_x_i;
    pby_q       <= pos_b_y_i;
    vel1_q[VAX] <= vel_a_x_i;
    vel1_q[VAY] <= vel_a_y_i;
    vel1_q[VBX] <= vel_b_x_i;
    vel1_q[VBY] <= vel_b_y_i;
    ma1_q       <= mass_a_i;
    mb1_q       <= mass_b_i;
  end

  // stage 2: center offset, relative velocity, magnitudes and signs
  logic signed [32:0] dx, dy, rvx, rvy;
  logic [31:0]        ma_fix, mb_fix;
  assign dx  = $signed({pbx_q[31], pbx_q}) - $signed({pax_q[31], pax_q});
  assign dy  = $signed({pby_q[31], pby_q}) - $signed({pay_q[31], pay_q});
  assign rvx = $signed({vel1_q[VBX][31], vel1_q[VBX]})
             - $signed({vel1_q[VAX][31], vel1_q[VAX]});
  assign rvy = $signed({vel1_q[VBY][31], vel1_q[VBY]})
             - $signed({vel1_q[VAY][31], vel1_q[VAY]});
  assign ma_fix = (ma1_q == '0) ? 32'd1 : ma1_q;
  assign mb_fix = (mb1_q == '0) ? 32'd1 : mb1_q;

  logic [31:0] adx_q, ady_q, arvx_q, arvy_q, ma2_q, mb2_q;
  logic        pxn2_q, pyn2_q, coinc2_q;
  logic [32:0] msum2_q;
  always_ff @(posedge clk_i) begin
    adx_q    <= dx[32] ? 32'(-dx) : dx[31:0];
    ady_q    <= dy[32] ? 32'(-dy) : dy[31:0];
    arvx_q   <= rvx[32] ? 32'(-rvx) : rvx[31:0];
    arvy_q   <= rvy[32] ? 32'(-rvy) : rvy[31:0];
    pxn2_q   <= rvx[32] ^ dx[32];
    pyn2_q   <= rvy[32] ^ dy[32];
    coinc2_q <= (dx == '0) && (dy == '0);
    ma2_q    <= ma_fix;
    mb2_q    <= mb_fix;
    msum2_q  <= 33'(ma_fix) + 33'(mb_fix);
  end

  // stage 3: 32x32 products
  logic [63:0] px_q, py_q, dx2_q, dy2_q;
  logic [63:0] g3_q [4];
  logic        pxn3_q, pyn3_q, coinc3_q;
  logic [32:0] msum3_q;
  always_ff @(posedge clk_i) begin
    px_q     <= arvx_q * adx_q;
    py_q     <= arvy_q * ady_q;
    dx2_q    <= adx_q * adx_q;
    dy2_q    <= ady_q * ady_q;
    g3_q[VAX] <= adx_q * mb2_q;
    g3_q[VAY] <= ady_q * mb2_q;
    g3_q[VBX] <= adx_q * ma2_q;
    g3_q[VBY] <= ady_q * ma2_q;
    pxn3_q   <= pxn2_q;
    pyn3_q   <= pyn2_q;
    coinc3_q <= coinc2_q;
    msum3_q  <= msum2_q;
  end

  // stage 4: signed dot product, separation test, squared distance
  logic signed [65:0] tx, ty, dotv;
  logic               skip;
  assign tx   = pxn3_q ? -$signed({2'b0, px_q}) : $signed({2'b0, px_q});
  assign ty   = pyn3_q ? -$signed({2'b0, py_q}) : $signed({2'b0, py_q});
  assign dotv = tx + ty;
  assign skip = coinc3_q | (~dotv[65] & (dotv != '0));

  logic [64:0] dot4_q, d2_4_q;
  logic [63:0] g4_q [4];
  logic [32:0] msum4_q;
  always_ff @(posedge clk_i) begin
    dot4_q  <= dotv[65] ? 65'(-dotv) : dotv[64:0];
    d2_4_q  <= 65'(dx2_q) + 65'(dy2_q);
    g4_q    <= g3_q;
    msum4_q <= msum3_q;
  end

  // stage 5: partial products of dot*(1+e) and d2*(mA+mB)
  logic [49:0] kp0_q, kp1_q;
  logic [17:0] kp2_q;
  logic [64:0] dp0_q, dp1_q;
  logic [32:0] dp2_q;
  logic [63:0] g5_q [4];
  always_ff @(posedge clk_i) begin
    kp0_q <= dot4_q[31:0] * f;
    kp1_q <= dot4_q[63:32] * f;
    kp2_q <= dot4_q[64] ? f : '0;
    dp0_q <= d2_4_q[31:0] * msum4_q;
    dp1_q <= d2_4_q[63:32] * msum4_q;
    dp2_q <= d2_4_q[64] ? msum4_q : '0;
    g5_q  <= g4_q;
  end

  // stage 6: sum partial products
  logic [95:0]  k6_q;
  logic [113:0] d6_q;
  logic [63:0]  g6_q [4];
  always_ff @(posedge clk_i) begin
    k6_q <= 96'(kp0_q) + (96'(kp1_q) << 32) + (96'(kp2_q) << 64);
    d6_q <= (114'(dp0_q) << 16) + (114'(dp1_q) << 48) + (114'(dp2_q) << 80);
    g6_q <= g5_q;
  end

  // stage 7: k times dmag*m, six partial products per lane
  logic [63:0]  pp7_q [4][3][2];
  logic [113:0] d7_q;
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 4; j++) begin
      for (int a = 0; a < 3; a++) begin
        for (int b = 0; b < 2; b++) begin
          pp7_q[j][a][b] <= k6_q[a*32 +: 32] * g6_q[j][b*32 +: 32];
        end
      end
    end
    d7_q <= d6_q;
  end

  // stage 8: row sums
  logic [114:0] slo8_q [4];
  logic [114:0] shi8_q [4];
  logic [113:0] d8_q;
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 4; j++) begin
      slo8_q[j] <= 115'(pp7_q[j][0][0]) + (115'(pp7_q[j][1][0]) << 32)
                 + (115'(pp7_q[j][2][0]) << 64);
      shi8_q[j] <= 115'(pp7_q[j][0][1]) + (115'(pp7_q[j][1][1]) << 32)
                 + (115'(pp7_q[j][2][1]) << 64);
    end
    d8_q <= d7_q;
  end

  // stage 9: rounding dividend 2N+D and divisor 2D
  logic [XW-1:0] x9_q [4];
  logic [YW-1:0] y9_q;
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 4; j++) begin
      x9_q[j] <= ((XW'(slo8_q[j]) + (XW'(shi8_q[j]) << 32)) << 1) + XW'(d8_q);
    end
    y9_q <= {d8_q, 1'b0};
  end

  // sideband pipeline, applied flag set at stage 4
  always_ff @(posedge clk_i) begin
    sb_q[2].vel        <= vel1_q;
    sb_q[2].minus[VAX] <= ~dx[32];
    sb_q[2].minus[VAY] <= ~dy[32];
    sb_q[2].minus[VBX] <= dx[32];
    sb_q[2].minus[VBY] <= dy[32];
    sb_q[2].applied    <= 1'b0;
    sb_q[3] <= sb_q[2];
    sb_q[4].vel     <= sb_q[3].vel;
    sb_q[4].minus   <= sb_q[3].minus;
    sb_q[4].applied <= ~skip;
    for (int n = 5; n <= 9; n++) begin
      sb_q[n] <= sb_q[n-1];
    end
  end

  // one pipelined divider per velocity component
  logic [3:0]    div_vld;
  logic [QW-1:0] div_q [4];
  logic [3:0]    div_ovf;
  for (genvar j = 0; j < 4; j++) begin : g_div
    cir_div_pipe #(
      .XW(XW),
      .YW(YW),
      .QW(QW)
    ) u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(vld_q[9]),
      .x_i    (x9_q[j]),
      .y_i    (y9_q),
      .valid_o(div_vld[j]),
      .q_o    (div_q[j]),
      .ovf_o  (div_ovf[j])
    );
  end

  // sideband delay matching the divider
  side_t sbd_q [0:QW];
  always_ff @(posedge clk_i) begin
    sbd_q[0] <= sb_q[9];
    for (int i = 1; i <= QW; i++) begin
      sbd_q[i] <= sbd_q[i-1];
    end
  end

  // apply impulse and saturate
  logic [3:0][31:0] vout;
  always_comb begin
    logic [QW:0]        qv;
    logic signed [37:0] sv;
    logic signed [37:0] qs;
    for (int j = 0; j < 4; j++) begin
      qv = div_ovf[j] ? {1'b1, {QW{1'b0}}} : {1'b0, div_q[j]};
      sv = 38'($signed(sbd_q[QW].vel[j]));
      qs = $signed({{(38-QW-1){1'b0}}, qv});
      vout[j] = sbd_q[QW].applied
              ? sat32(sbd_q[QW].minus[j] ? (sv - qs) : (sv + qs))
              : sbd_q[QW].vel[j];
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= &div_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    new_vel_a_x_o <= vout[VAX];
    new_vel_a_y_o <= vout[VAY];
    new_vel_b_x_o <= vout[VBX];
    new_vel_b_y_o <= vout[VBY];
    applied_o     <= sbd_q[QW].applied;
  end

`ifndef ASSERT_OFF
  a_restitution_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    restitution_q <= E_ONE)
    else $error("restitution register above 1.0");

  a_done_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, LAT))
    else $error("result without matching request");

  a_applied_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[4] && sb_q[4].applied) |-> (d2_4_q != '0))
    else $error("impulse applied with coincident centers");

  a_div_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_vld != '0) |-> (div_vld == 4'hf))
    else $error("divider lanes out of step");
`endif

endmodule
`default_nettype wire
